>>> hw/rtl/ges_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient energy stencil package
// Shared constants, register codes and item types of the stencil block.
// ----------------------------------------------------------------------------
package ges_pkg;

    localparam int MAX_GRID_DEF = 64;
    localparam int MIN_GRID     = 3;
    localparam int SAMPLE_W     = 16;
    localparam int POS_W        = 6;
    localparam int GRAD_W       = 24;
    localparam int TOTAL_W      = 64;
    localparam int GRID_REG_W   = 7;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 160;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [GRID_REG_W-1:0] GRID_RESET = 7'd10;
    localparam logic [CFG_W-1:0]      INV_RESET  = 16'd128;
    localparam logic [CFG_W-1:0]      VOL_RESET  = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE = 2'd0,
        CFG_INV_TWO_DX = 2'd1,
        CFG_VOLUME = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cfg_wr_t;

    typedef struct packed {
        logic [CFG_W-1:0] inv_two_dx;
        logic [CFG_W-1:0] volume_element;
    } arith_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] potential;
        logic signed [SAMPLE_W-1:0] field;
        logic                       interior;
        logic                       last;
        logic [POS_W-1:0]           x;
        logic [POS_W-1:0]           y;
        logic [POS_W-1:0]           z;
    } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/ges_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ges_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/ges_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Item queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module ges_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] dout,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ges_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stencil front end
// Holds configuration and grid geometry, counts voxels and classifies each
// item as interior, boundary or last before it enters the queue.
// ----------------------------------------------------------------------------
module ges_front
    import ges_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cfg_wr_t                               cfg,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [SAMPLE_W-1:0]                   in_potential,
    input  wire logic [SAMPLE_W-1:0]                   in_field,
    output logic                                       q_push,
    output item_t                                      q_item,
    input  wire logic                                  q_full,
    output logic      [$clog2(MAX_GRID+1)-1:0]          g,
    output logic      [$clog2(MAX_GRID*MAX_GRID+1)-1:0] g2,
    output arith_cfg_t                                 acfg
);

    localparam int GW   = $clog2(MAX_GRID + 1);
    localparam int G2W  = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int NW   = $clog2(MAX_GRID * MAX_GRID * MAX_GRID + 1);
    localparam int CNTW = $clog2(MAX_GRID * MAX_GRID * MAX_GRID);
    localparam int CW   = $clog2(MAX_GRID);
    localparam int SW   = $clog2(CNTW);

    typedef enum logic [1:0] {F_GEO1, F_GEO2, F_DIV, F_RUN} fstate_t;

    fstate_t              state_reg, state_next;
    logic [GRID_REG_W-1:0] grid_reg, grid_next;
    arith_cfg_t           acfg_reg, acfg_next;
    logic [GW-1:0]        g_reg, g_next;
    logic [G2W-1:0]       g2_reg, g2_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [CNTW-1:0]      c_reg, c_next;
    logic [CW-1:0]        x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CNTW-1:0]      num_reg, num_next;
    logic [GW:0]          rem_reg, rem_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 pass_reg, pass_next;

    logic [GW-1:0]   g_clamp;
    logic [GW:0]     rem_sh;
    logic            rem_ge;
    logic            accept;
    logic            is_last;
    logic            past_plane;
    logic            interior;

    always_comb
    begin
        if (int'(grid_reg) < MIN_GRID)
        begin
            g_clamp = GW'(MIN_GRID);
        end
        else if (int'(grid_reg) > MAX_GRID)
        begin
            g_clamp = GW'(MAX_GRID);
        end
        else
        begin
            g_clamp = GW'(grid_reg);
        end
    end

    assign rem_sh     = {rem_reg[GW-1:0], num_reg[CNTW-1]};
    assign rem_ge     = (rem_sh >= {1'b0, g_reg});
    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == F_RUN) && !q_full;
    assign is_last    = ((NW+1)'(c_reg) + 1'b1) >= (NW+1)'(n_reg);
    assign past_plane = (NW'(c_reg) >= NW'(g2_reg));
    assign interior   = !is_last && past_plane
                        && (x_reg != '0) && ((GW+1)'(x_reg) + 2'd2 <= (GW+1)'(g_reg))
                        && (y_reg != '0) && ((GW+1)'(y_reg) + 2'd2 <= (GW+1)'(g_reg))
                        && (z_reg != '0) && ((GW+1)'(z_reg) + 2'd2 <= (GW+1)'(g_reg));

    always_comb
    begin
        state_next = state_reg;
        grid_next  = grid_reg;
        acfg_next  = acfg_reg;
        g_next     = g_reg;
        g2_next    = g2_reg;
        n_next     = n_reg;
        c_next     = c_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        pass_next  = pass_reg;

        unique case (state_reg)
            F_GEO1:
            begin
                g_next     = g_clamp;
                g2_next    = G2W'(g_clamp * g_clamp);
                state_next = F_GEO2;
            end
            F_GEO2:
            begin
                n_next = NW'(g2_reg * g_reg);
                if (past_plane)
                begin
                    num_next   = c_reg - CNTW'(g2_reg);
                    rem_next   = '0;
                    step_next  = '0;
                    pass_next  = 1'b0;
                    state_next = F_DIV;
                end
                else
                begin
                    x_next     = '0;
                    y_next     = '0;
                    z_next     = '0;
                    state_next = F_RUN;
                end
            end
            F_DIV:
            begin
                num_next  = {num_reg[CNTW-2:0], rem_ge};
                rem_next  = rem_ge ? rem_sh - {1'b0, g_reg} : rem_sh;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(CNTW - 1))
                begin
                    step_next = '0;
                    if (!pass_reg)
                    begin
                        x_next    = CW'(rem_next);
                        rem_next  = '0;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        y_next     = CW'(rem_next);
                        z_next     = CW'(num_next);
                        state_next = F_RUN;
                    end
                end
            end
            F_RUN:
            begin
                if (accept)
                begin
                    if (is_last)
                    begin
                        c_next = '0;
                        x_next = '0;
                        y_next = '0;
                        z_next = '0;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                        if (past_plane)
                        begin
                            if (GW'(x_reg) + 1'b1 == g_reg)
                            begin
                                x_next = '0;
                                if (GW'(y_reg) + 1'b1 == g_reg)
                                begin
                                    y_next = '0;
                                    z_next = z_reg + 1'b1;
                                end
                                else
                                begin
                                    y_next = y_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                x_next = x_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = F_GEO1;
            end
        endcase

        if (cfg.we)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_GRID_SIZE:
                begin
                    grid_next  = GRID_REG_W'(cfg.data);
                    state_next = F_GEO1;
                end
                CFG_INV_TWO_DX: acfg_next.inv_two_dx = cfg.data;
                CFG_VOLUME:     acfg_next.volume_element = cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_GEO1;
            grid_reg  <= GRID_RESET;
            acfg_reg  <= '{inv_two_dx: INV_RESET, volume_element: VOL_RESET};
            g_reg     <= '0;
            g2_reg    <= '0;
            n_reg     <= '0;
            c_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grid_reg  <= grid_next;
            acfg_reg  <= acfg_next;
            g_reg     <= g_next;
            g2_reg    <= g2_next;
            n_reg     <= n_next;
            c_reg     <= c_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            num_reg   <= num_next;
            rem_reg   <= rem_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    assign q_push           = accept;
    assign q_item.potential = in_potential;
    assign q_item.field     = in_field;
    assign q_item.interior  = interior;
    assign q_item.last      = is_last;
    assign q_item.x         = POS_W'(x_reg);
    assign q_item.y         = POS_W'(y_reg);
    assign q_item.z         = POS_W'(z_reg);
    assign g                = g_reg;
    assign g2               = g2_reg;
    assign acfg             = acfg_reg;

`ifndef ASSERT_OFF
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_RUN |-> (GW'(x_reg) < g_reg) && (GW'(y_reg) < g_reg))
        else $error("coordinate beyond grid edge");
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> c_reg == '0) else $error("counter not cleared");
    a_interior_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !(q_item.interior && q_item.last)) else $error("bad class");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/ges_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stencil back end
// Reads the neighbor samples from the history memories, forms the gradient
// and energy term in a sequence of registered arithmetic steps and drives
// the result register.
// ----------------------------------------------------------------------------
module ges_back
    import ges_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [$clog2(MAX_GRID+1)-1:0]          g,
    input  wire logic [$clog2(MAX_GRID*MAX_GRID+1)-1:0] g2,
    input  wire arith_cfg_t                            acfg,
    input  wire item_t                                 q_item,
    input  wire logic                                  q_empty,
    output logic                                       q_pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [POS_W-1:0]                      pos_x,
    output logic      [POS_W-1:0]                      pos_y,
    output logic      [POS_W-1:0]                      pos_z,
    output logic      [GRAD_W-1:0]                     grad_x,
    output logic      [GRAD_W-1:0]                     grad_y,
    output logic      [GRAD_W-1:0]                     grad_z,
    output logic      [TOTAL_W-1:0]                    power_total,
    output logic                                       is_total
);

    localparam int WIN_DEPTH = 2 * MAX_GRID * MAX_GRID + MAX_GRID;
    localparam int FLD_DEPTH = MAX_GRID * MAX_GRID;
    localparam int WAW = $clog2(WIN_DEPTH);
    localparam int FAW = $clog2(FLD_DEPTH);

    typedef enum logic [3:0] {
        B_IDLE, B_RD, B_CAP, B_MUL, B_SAT, B_SQ, B_SUM,
        B_VOL, B_WGT, B_ACC, B_OUT, B_WR
    } bstate_t;

    bstate_t                    state_reg, state_next;
    item_t                      cur_reg, cur_next;
    logic [2:0]                 idx_reg, idx_next;
    logic [WAW-1:0]             win_ptr_reg, win_ptr_next;
    logic [FAW-1:0]             fld_ptr_reg, fld_ptr_next;
    logic signed [SAMPLE_W-1:0] pw_reg [5];
    logic signed [SAMPLE_W-1:0] wcen_reg;
    logic signed [33:0]         prod_reg, prod_next;
    logic signed [GRAD_W-1:0]   gr_reg [3];
    logic [47:0]                sq_reg, sq_next;
    logic [48:0]                s_reg, s_next;
    logic [51:0]                v_reg, v_next;
    logic signed [61:0]         w_reg, w_next;
    logic signed [TOTAL_W-1:0]  acc_reg, acc_next;
    logic                       ov_reg, ov_next;
    logic [POS_W-1:0]           px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [GRAD_W-1:0]          gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic [TOTAL_W-1:0]         tot_reg, tot_next;
    logic                       ist_reg, ist_next;

    logic [WAW:0]               k;
    logic [WAW:0]               win_raddr_w;
    logic [FAW:0]               fld_raddr_w;
    logic [WAW-1:0]             win_raddr;
    logic [FAW-1:0]             fld_raddr;
    logic [SAMPLE_W-1:0]        win_rdata;
    logic [SAMPLE_W-1:0]        fld_rdata;
    logic                       out_free;
    logic                       wr_en;
    logic signed [16:0]         diff;
    logic signed [16:0]         inv_s;
    logic signed [33:0]         rnd8;
    logic signed [GRAD_W-1:0]   gsel;
    logic signed [47:0]         gsq;
    logic [49:0]                s_rnd;
    logic [52:0]                v_rnd;
    logic signed [62:0]         w_rnd;
    logic signed [TOTAL_W:0]    acc_sum;

    always_comb
    begin
        case (idx_reg)
            3'd0:    k = (WAW+1)'(g2) - 1'b1;
            3'd1:    k = (WAW+1)'(g2) + 1'b1;
            3'd2:    k = (WAW+1)'(g2) - (WAW+1)'(g);
            3'd3:    k = (WAW+1)'(g2) + (WAW+1)'(g);
            default: k = (WAW+1)'(g2) << 1;
        endcase
    end

    assign win_raddr_w = ((WAW+1)'(win_ptr_reg) >= k)
                         ? (WAW+1)'(win_ptr_reg) - k
                         : (WAW+1)'(win_ptr_reg) + (WAW+1)'(WIN_DEPTH) - k;
    assign fld_raddr_w = ((FAW+1)'(fld_ptr_reg) >= (FAW+1)'(g2))
                         ? (FAW+1)'(fld_ptr_reg) - (FAW+1)'(g2)
                         : (FAW+1)'(fld_ptr_reg) + (FAW+1)'(FLD_DEPTH) - (FAW+1)'(g2);
    assign win_raddr   = win_raddr_w[WAW-1:0];
    assign fld_raddr   = fld_raddr_w[FAW-1:0];

    assign out_free = !ov_reg || out_ready;
    assign wr_en    = (state_reg == B_WR) || ((state_reg == B_OUT) && out_free);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    ges_ram #(.WIDTH(SAMPLE_W), .DEPTH(WIN_DEPTH)) u_win_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (win_ptr_reg),
        .wdata (cur_reg.potential),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    ges_ram #(.WIDTH(SAMPLE_W), .DEPTH(FLD_DEPTH)) u_fld_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (fld_ptr_reg),
        .wdata (cur_reg.field),
        .raddr (fld_raddr),
        .rdata (fld_rdata)
    );

    always_comb
    begin
        case (idx_reg)
            3'd0:    diff = 17'(pw_reg[0]) - 17'(pw_reg[1]);
            3'd1:    diff = 17'(pw_reg[2]) - 17'(pw_reg[3]);
            default: diff = 17'(cur_reg.potential) - 17'(pw_reg[4]);
        endcase
        case (idx_reg)
            3'd0:    gsel = gr_reg[0];
            3'd1:    gsel = gr_reg[1];
            default: gsel = gr_reg[2];
        endcase
    end

    assign inv_s   = $signed({1'b0, acfg.inv_two_dx});
    assign rnd8    = (prod_reg + 34'sd128) >>> 8;
    assign gsq     = gsel * gsel;
    assign s_rnd   = ({1'b0, s_reg} + 50'd8192) >> 14;
    assign v_rnd   = ({1'b0, v_reg} + 53'd128) >> 8;
    assign w_rnd   = (63'(w_reg) + 63'sd8192) >>> 14;
    assign acc_sum = (TOTAL_W+1)'(acc_reg) + (TOTAL_W+1)'(w_rnd);

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        win_ptr_next = win_ptr_reg;
        fld_ptr_next = fld_ptr_reg;
        prod_next    = prod_reg;
        sq_next      = sq_reg;
        s_next       = s_reg;
        v_next       = v_reg;
        w_next       = w_reg;
        acc_next     = acc_reg;
        ov_next      = ov_reg && !out_ready;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        gz_next      = gz_reg;
        tot_next     = tot_reg;
        ist_next     = ist_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cur_next = q_item;
                    idx_next = '0;
                    s_next   = '0;
                    if (q_item.interior)
                    begin
                        state_next = B_RD;
                    end
                    else if (q_item.last)
                    begin
                        state_next = B_OUT;
                    end
                    else
                    begin
                        state_next = B_WR;
                    end
                end
            end
            B_RD:
            begin
                state_next = B_CAP;
            end
            B_CAP:
            begin
                if (idx_reg == 3'd4)
                begin
                    idx_next   = '0;
                    state_next = B_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_MUL:
            begin
                prod_next  = diff * inv_s;
                state_next = B_SAT;
            end
            B_SAT:
            begin
                if (idx_reg == 3'd2)
                begin
                    idx_next   = '0;
                    state_next = B_SQ;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_MUL;
                end
            end
            B_SQ:
            begin
                sq_next    = 48'(gsq);
                state_next = B_SUM;
            end
            B_SUM:
            begin
                s_next = s_reg + 49'(sq_reg);
                if (idx_reg == 3'd2)
                begin
                    state_next = B_VOL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_SQ;
                end
            end
            B_VOL:
            begin
                v_next     = 52'(36'(s_rnd) * acfg.volume_element);
                state_next = B_WGT;
            end
            B_WGT:
            begin
                w_next     = $signed({1'b0, 45'(v_rnd)}) * wcen_reg;
                state_next = B_ACC;
            end
            B_ACC:
            begin
                if (acc_sum > $signed((TOTAL_W+1)'({1'b0, {(TOTAL_W-1){1'b1}}})))
                begin
                    acc_next = {1'b0, {(TOTAL_W-1){1'b1}}};
                end
                else if (acc_sum < $signed({2'b11, {(TOTAL_W-1){1'b0}}}))
                begin
                    acc_next = {1'b1, {(TOTAL_W-1){1'b0}}};
                end
                else
                begin
                    acc_next = TOTAL_W'(acc_sum);
                end
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    ist_next = cur_reg.last;
                    if (cur_reg.last)
                    begin
                        px_next  = '0;
                        py_next  = '0;
                        pz_next  = '0;
                        gx_next  = '0;
                        gy_next  = '0;
                        gz_next  = '0;
                        tot_next = acc_reg;
                        acc_next = '0;
                    end
                    else
                    begin
                        px_next  = cur_reg.x;
                        py_next  = cur_reg.y;
                        pz_next  = cur_reg.z;
                        gx_next  = gr_reg[0];
                        gy_next  = gr_reg[1];
                        gz_next  = gr_reg[2];
                        tot_next = '0;
                    end
                    win_ptr_next = (win_ptr_reg == WAW'(WIN_DEPTH - 1)) ? '0
                                   : win_ptr_reg + 1'b1;
                    fld_ptr_next = (fld_ptr_reg == FAW'(FLD_DEPTH - 1)) ? '0
                                   : fld_ptr_reg + 1'b1;
                    state_next   = B_IDLE;
                end
            end
            B_WR:
            begin
                win_ptr_next = (win_ptr_reg == WAW'(WIN_DEPTH - 1)) ? '0
                               : win_ptr_reg + 1'b1;
                fld_ptr_next = (fld_ptr_reg == FAW'(FLD_DEPTH - 1)) ? '0
                               : fld_ptr_reg + 1'b1;
                state_next   = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_CAP)
        begin
            pw_reg[idx_reg] <= $signed(win_rdata);
            if (idx_reg == 3'd0)
            begin
                wcen_reg <= $signed(fld_rdata);
            end
        end
        if (state_reg == B_SAT)
        begin
            if (rnd8 > 34'sd8388607)
            begin
                gr_reg[idx_reg[1:0]] <= 24'sh7FFFFF;
            end
            else if (rnd8 < -34'sd8388608)
            begin
                gr_reg[idx_reg[1:0]] <= 24'sh800000;
            end
            else
            begin
                gr_reg[idx_reg[1:0]] <= GRAD_W'(rnd8);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            cur_reg     <= '0;
            idx_reg     <= '0;
            win_ptr_reg <= '0;
            fld_ptr_reg <= '0;
            prod_reg    <= '0;
            sq_reg      <= '0;
            s_reg       <= '0;
            v_reg       <= '0;
            w_reg       <= '0;
            acc_reg     <= '0;
            ov_reg      <= 1'b0;
            px_reg      <= '0;
            py_reg      <= '0;
            pz_reg      <= '0;
            gx_reg      <= '0;
            gy_reg      <= '0;
            gz_reg      <= '0;
            tot_reg     <= '0;
            ist_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            idx_reg     <= idx_next;
            win_ptr_reg <= win_ptr_next;
            fld_ptr_reg <= fld_ptr_next;
            prod_reg    <= prod_next;
            sq_reg      <= sq_next;
            s_reg       <= s_next;
            v_reg       <= v_next;
            w_reg       <= w_next;
            acc_reg     <= acc_next;
            ov_reg      <= ov_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            pz_reg      <= pz_next;
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            gz_reg      <= gz_next;
            tot_reg     <= tot_next;
            ist_reg     <= ist_next;
        end
    end

    assign out_valid   = ov_reg;
    assign pos_x       = px_reg;
    assign pos_y       = py_reg;
    assign pos_z       = pz_reg;
    assign grad_x      = gx_reg;
    assign grad_y      = gy_reg;
    assign grad_z      = gz_reg;
    assign power_total = tot_reg;
    assign is_total    = ist_reg;

`ifndef ASSERT_OFF
    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != B_IDLE) else $error("pop without work");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(win_ptr_reg) < WIN_DEPTH) else $error("window pointer out of range");
    a_total_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ist_reg |-> gx_reg == '0 && gy_reg == '0 && gz_reg == '0)
        else $error("total item carries gradient");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/gradient_energy_stencil_3d_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient energy stencil, top level
// Central-difference gradient and weighted energy total over a cubic grid.
// ----------------------------------------------------------------------------
// Voxels enter in raster order with x fastest. An interior voxel takes longer
// in the back end than a boundary voxel, set by the single read port of the
// potential history memory (five neighbor reads) and the arithmetic that runs
// one step per cycle for the gradients, squares and energy term. A queue of
// four items lets the front keep accepting while the back works. After a
// grid_size write the front recomputes its geometry in the states F_GEO1 and
// F_GEO2, and when the voxel counter is past the first plane it also
// recomputes the coordinates by bit-serial division in F_DIV before it takes
// the next item. The total item closes each grid.
module gradient_energy_stencil_3d_top
    import ges_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // potential_sample, field_sample
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pos_x, pos_y, pos_z, grad_x, grad_y, grad_z, power_total, zero fill
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // is_total
    output logic      [0:0]             m_tuser,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int GW  = $clog2(MAX_GRID + 1);
    localparam int G2W = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int IW  = $bits(item_t);
    localparam int PAD = OUT_TDATA_W - 3 * POS_W - 3 * GRAD_W - TOTAL_W;

    cfg_wr_t            cfg;
    arith_cfg_t         acfg;
    item_t              push_item;
    item_t              pop_item;
    logic [IW-1:0]      pop_bits;
    logic               q_push, q_pop, q_full, q_empty;
    logic [GW-1:0]      g;
    logic [G2W-1:0]     g2;
    logic [POS_W-1:0]   pos_x, pos_y, pos_z;
    logic [GRAD_W-1:0]  grad_x, grad_y, grad_z;
    logic [TOTAL_W-1:0] power_total;
    logic               is_total;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    ges_front #(.MAX_GRID(MAX_GRID)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_potential (s_tdata[SAMPLE_W-1:0]),
        .in_field     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .q_push       (q_push),
        .q_item       (push_item),
        .q_full       (q_full),
        .g            (g),
        .g2           (g2),
        .acfg         (acfg)
    );

    ges_fifo #(.WIDTH(IW), .DEPTH(FIFO_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_item),
        .pop   (q_pop),
        .dout  (pop_bits),
        .full  (q_full),
        .empty (q_empty)
    );

    assign pop_item = item_t'(pop_bits);

    ges_back #(.MAX_GRID(MAX_GRID)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .g           (g),
        .g2          (g2),
        .acfg        (acfg),
        .q_item      (pop_item),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .power_total (power_total),
        .is_total    (is_total)
    );

    assign m_tdata = {{PAD{1'b0}}, power_total, grad_z, grad_y, grad_x,
                      pos_z, pos_y, pos_x};
    assign m_tuser = is_total;

endmodule
`default_nettype wire
